@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

@@ rtl/dapsp_pkg.sv @@
// Shared types, constants and the angle to compare-value mapping.
package dapsp_pkg;

    localparam int GAIN_BITS    = 24;
    localparam int CENTER_BITS  = 10;
    localparam int ANGLE_BITS   = 8;
    localparam int PWM_BITS     = 12;
    localparam int FRAC_BITS    = 16;
    localparam int CENTER_ANGLE = 90;
    localparam int PWM_OFFSET   = 655;
    localparam int PWM_LIMIT    = 4095;
    // angle*14.56 = angle*364/25; 364*ceil(2^22/25) = 61069372, exact for 8-bit angles
    localparam int PWM_RECIP    = 61069372;
    localparam int RECIP_BITS   = 26;
    localparam int PWM_SHIFT    = 22;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;

    typedef enum logic [2:0] {
        REG_KP_X,
        REG_KI_X,
        REG_KD_X,
        REG_KP_Y,
        REG_KI_Y,
        REG_KD_Y,
        REG_CENTER_X,
        REG_CENTER_Y
    } reg_idx_t;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] kp;
        logic signed [GAIN_BITS-1:0] ki;
        logic signed [GAIN_BITS-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic                  valid;
        logic [ANGLE_BITS-1:0] angle;
    } lane_res_t;

    function automatic logic [PWM_BITS-1:0] pwm_of(input logic [ANGLE_BITS-1:0] ang);
        logic [ANGLE_BITS+RECIP_BITS-1:0] prod;
        logic [PWM_BITS:0]                p;
        prod = (ANGLE_BITS+RECIP_BITS)'(ang) * (ANGLE_BITS+RECIP_BITS)'(PWM_RECIP);
        p    = (PWM_BITS+1)'(prod >> PWM_SHIFT) + (PWM_BITS+1)'(PWM_OFFSET);
        if (p > (PWM_BITS+1)'(PWM_LIMIT)) begin
            return PWM_BITS'(PWM_LIMIT);
        end
        return p[PWM_BITS-1:0];
    endfunction

endpackage

@@ rtl/dapsp_lane.sv @@
// One PID lane: saturating integral, shared multiplier over three terms, clamp.
module dapsp_lane import dapsp_pkg::*; #(
    parameter int POS_BITS      = 10,
    parameter int INTEGRAL_BITS = 24,
    parameter int ANGLE_MIN     = 45,
    parameter int ANGLE_MAX     = 135
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [POS_BITS:0] err,
    input  gains_t                   gains,
    input  logic                     res_ready,
    output logic                     idle,
    output lane_res_t                res
);

    localparam int IB        = INTEGRAL_BITS;
    localparam int PROD_BITS = GAIN_BITS + IB;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam int ANG_W     = SUM_BITS - FRAC_BITS + 1;

    localparam logic signed [IB:0] IMAX_W = (IB+1)'((longint'(1) << (IB-1)) - 1);
    localparam logic signed [IB:0] IMIN_W = -IMAX_W - (IB+1)'(1);
    localparam logic signed [ANG_W-1:0] AMAX_W = ANG_W'(ANGLE_MAX);
    localparam logic signed [ANG_W-1:0] AMIN_W = ANG_W'(ANGLE_MIN);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL0,
        L_MUL1,
        L_MUL2,
        L_ADD,
        L_ANG,
        L_HOLD
    } state_t;

    state_t                      state_reg, state_next;
    logic signed [IB-1:0]        integ_reg, integ_next;
    logic signed [POS_BITS:0]    last_reg, last_next;
    logic [ANGLE_BITS-1:0]       angle_reg, angle_next;
    logic signed [IB-1:0]        err_reg, diff_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [SUM_BITS-1:0]  sum_reg;

    logic signed [IB:0]          acc_wide;
    logic signed [IB-1:0]        acc_sat;
    logic signed [GAIN_BITS-1:0] op_a;
    logic signed [IB-1:0]        op_b;
    logic signed [SUM_BITS-1:0]  shifted;
    logic signed [ANG_W-1:0]     ang_full;
    logic [ANGLE_BITS-1:0]       ang_clamp;

    always_comb begin
        acc_wide = (IB+1)'(integ_reg) + (IB+1)'(err);
        if (acc_wide > IMAX_W) begin
            acc_sat = IMAX_W[IB-1:0];
        end else if (acc_wide < IMIN_W) begin
            acc_sat = IMIN_W[IB-1:0];
        end else begin
            acc_sat = acc_wide[IB-1:0];
        end
    end

    // multiplier operand select per step
    always_comb begin
        case (state_reg)
            L_MUL0: begin
                op_a = gains.kp;
                op_b = err_reg;
            end
            L_MUL1: begin
                op_a = gains.ki;
                op_b = integ_reg;
            end
            default: begin
                op_a = gains.kd;
                op_b = diff_reg;
            end
        endcase
    end

    // floor(sum / 2^16) + 90, max test first, then min
    always_comb begin
        shifted  = sum_reg >>> FRAC_BITS;
        ang_full = ANG_W'(shifted) + ANG_W'(CENTER_ANGLE);
        if (ang_full > AMAX_W) begin
            ang_clamp = ANGLE_BITS'(ANGLE_MAX);
        end else if (ang_full < AMIN_W) begin
            ang_clamp = ANGLE_BITS'(ANGLE_MIN);
        end else begin
            ang_clamp = ang_full[ANGLE_BITS-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        integ_next = integ_reg;
        last_next  = last_reg;
        angle_next = angle_reg;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    integ_next = acc_sat;
                    last_next  = err;
                    state_next = L_MUL0;
                end
            end
            L_MUL0: state_next = L_MUL1;
            L_MUL1: state_next = L_MUL2;
            L_MUL2: state_next = L_ADD;
            L_ADD:  state_next = L_ANG;
            L_ANG: begin
                angle_next = ang_clamp;
                state_next = L_HOLD;
            end
            L_HOLD: begin
                if (res_ready) begin
                    state_next = L_IDLE;
                end
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            integ_reg <= '0;
            last_reg  <= '0;
            angle_reg <= '0;
        end else begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            last_reg  <= last_next;
            angle_reg <= angle_next;
        end
    end

    // datapath: product register, then accumulate one step behind
    always_ff @(posedge aclk) begin
        if (state_reg == L_IDLE && start) begin
            err_reg  <= IB'(err);
            diff_reg <= IB'(err) - IB'(last_reg);
        end
        prod_reg <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
        if (state_reg == L_MUL1) begin
            sum_reg <= SUM_BITS'(prod_reg);
        end else if (state_reg == L_MUL2 || state_reg == L_ADD) begin
            sum_reg <= sum_reg + SUM_BITS'(prod_reg);
        end
    end

    assign idle      = (state_reg == L_IDLE);
    assign res.valid = (state_reg == L_HOLD);
    assign res.angle = angle_reg;

endmodule

@@ rtl/dapsp_merge.sv @@
// Merge stage: joins both lane angles, maps them to compare values, output register.
module dapsp_merge import dapsp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lane_res_t             res_x,
    input  lane_res_t             res_y,
    output logic                  take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ANGLE_BITS-1:0] m_angle_x,
    output logic [ANGLE_BITS-1:0] m_angle_y,
    output logic [PWM_BITS-1:0]   m_pwm_x,
    output logic [PWM_BITS-1:0]   m_pwm_y
);

    logic                  valid_reg;
    logic [ANGLE_BITS-1:0] angle_x_reg, angle_y_reg;
    logic [PWM_BITS-1:0]   pwm_x_reg, pwm_y_reg;

    assign take = res_x.valid & res_y.valid & (~valid_reg | m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            angle_x_reg <= res_x.angle;
            angle_y_reg <= res_y.angle;
            pwm_x_reg   <= pwm_of(res_x.angle);
            pwm_y_reg   <= pwm_of(res_y.angle);
        end
    end

    assign m_valid   = valid_reg;
    assign m_angle_x = angle_x_reg;
    assign m_angle_y = angle_y_reg;
    assign m_pwm_x   = pwm_x_reg;
    assign m_pwm_y   = pwm_y_reg;

endmodule

@@ rtl/dual_axis_pid_servo_pwm.sv @@
// Two-axis PID servo controller top level: config registers, two lanes, merge stage.
// A request is worked through the lane states and then the merge output register.
// Requests are not overlapped; each lane's single multiplier steps through
//   the P, I and D products, then an add, the clamp, and the hand-off to merge.
// The output register decouples the sides: a new request is taken while a result waits.
// Reset (aresetn, synchronous, active low) loads default gains and set point and
//   clears integrals, previous errors and all handshake state.
module dual_axis_pid_servo_pwm import dapsp_pkg::*; #(
    parameter int POS_BITS      = 10,
    parameter int ANGLE_MIN     = 45,
    parameter int ANGLE_MAX     = 135,
    parameter int INTEGRAL_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    // position requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [POS_BITS-1:0]   s_pos_x,
    input  logic [POS_BITS-1:0]   s_pos_y,
    // servo results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ANGLE_BITS-1:0] m_angle_x,
    output logic [ANGLE_BITS-1:0] m_angle_y,
    output logic [PWM_BITS-1:0]   m_pwm_x,
    output logic [PWM_BITS-1:0]   m_pwm_y
);

    // center is stored at its register width, then cut or zero-padded to POS_BITS
    localparam int CW = (POS_BITS > CENTER_BITS) ? POS_BITS : CENTER_BITS;

    localparam logic [GAIN_BITS-1:0]   KP_X_RST     = GAIN_BITS'(6912);
    localparam logic [GAIN_BITS-1:0]   KI_X_RST     = GAIN_BITS'(92);
    localparam logic [GAIN_BITS-1:0]   KD_X_RST     = GAIN_BITS'(79439);
    localparam logic [GAIN_BITS-1:0]   KP_Y_RST     = GAIN_BITS'(9216);
    localparam logic [GAIN_BITS-1:0]   KI_Y_RST     = GAIN_BITS'(123);
    localparam logic [GAIN_BITS-1:0]   KD_Y_RST     = GAIN_BITS'(105921);
    localparam logic [CENTER_BITS-1:0] CENTER_X_RST = CENTER_BITS'(320);
    localparam logic [CENTER_BITS-1:0] CENTER_Y_RST = CENTER_BITS'(240);

    logic [GAIN_BITS-1:0]   kp_x_reg, ki_x_reg, kd_x_reg;
    logic [GAIN_BITS-1:0]   kp_y_reg, ki_y_reg, kd_y_reg;
    logic [CENTER_BITS-1:0] center_x_reg, center_y_reg;

    reg_idx_t reg_idx;
    logic     cfg_write;

    logic [CW-1:0]           cx_wide, cy_wide;
    logic [POS_BITS-1:0]     cx_pos, cy_pos;
    logic signed [POS_BITS:0] err_x, err_y;

    gains_t    gains_x, gains_y;
    lane_res_t res_x, res_y;
    logic      idle_x, idle_y;
    logic      start;
    logic      take;

    // ---------------- configuration ----------------
    // Register i sits at byte address 4*i; the low two address bits are ignored.
    assign reg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_x_reg     <= KP_X_RST;
            ki_x_reg     <= KI_X_RST;
            kd_x_reg     <= KD_X_RST;
            kp_y_reg     <= KP_Y_RST;
            ki_y_reg     <= KI_Y_RST;
            kd_y_reg     <= KD_Y_RST;
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_KP_X:     kp_x_reg     <= pwdata[GAIN_BITS-1:0];
                REG_KI_X:     ki_x_reg     <= pwdata[GAIN_BITS-1:0];
                REG_KD_X:     kd_x_reg     <= pwdata[GAIN_BITS-1:0];
                REG_KP_Y:     kp_y_reg     <= pwdata[GAIN_BITS-1:0];
                REG_KI_Y:     ki_y_reg     <= pwdata[GAIN_BITS-1:0];
                REG_KD_Y:     kd_y_reg     <= pwdata[GAIN_BITS-1:0];
                REG_CENTER_X: center_x_reg <= pwdata[CENTER_BITS-1:0];
                REG_CENTER_Y: center_y_reg <= pwdata[CENTER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read-back: gains and centers zero-extended to the bus width.
    always_comb begin
        case (reg_idx)
            REG_KP_X:     prdata = DATA_BITS'(kp_x_reg);
            REG_KI_X:     prdata = DATA_BITS'(ki_x_reg);
            REG_KD_X:     prdata = DATA_BITS'(kd_x_reg);
            REG_KP_Y:     prdata = DATA_BITS'(kp_y_reg);
            REG_KI_Y:     prdata = DATA_BITS'(ki_y_reg);
            REG_KD_Y:     prdata = DATA_BITS'(kd_y_reg);
            REG_CENTER_X: prdata = DATA_BITS'(center_x_reg);
            REG_CENTER_Y: prdata = DATA_BITS'(center_y_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        gains_x.kp = kp_x_reg;
        gains_x.ki = ki_x_reg;
        gains_x.kd = kd_x_reg;
        gains_y.kp = kp_y_reg;
        gains_y.ki = ki_y_reg;
        gains_y.kd = kd_y_reg;
    end

    // ---------------- error formation ----------------
    // X error is set point minus position, Y error is position minus set point.
    // Both fit POS_BITS+1 signed bits.
    assign cx_wide = CW'(center_x_reg);
    assign cy_wide = CW'(center_y_reg);
    assign cx_pos  = cx_wide[POS_BITS-1:0];
    assign cy_pos  = cy_wide[POS_BITS-1:0];
    assign err_x   = signed'({1'b0, cx_pos} - {1'b0, s_pos_x});
    assign err_y   = signed'({1'b0, s_pos_y} - {1'b0, cy_pos});

    // One request in flight: both lanes must be back to idle.
    assign s_ready = idle_x & idle_y;
    assign start   = s_valid & s_ready;

    // ---------------- lanes ----------------
    dapsp_lane #(
        .POS_BITS      (POS_BITS),
        .INTEGRAL_BITS (INTEGRAL_BITS),
        .ANGLE_MIN     (ANGLE_MIN),
        .ANGLE_MAX     (ANGLE_MAX)
    ) u_lane_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .err       (err_x),
        .gains     (gains_x),
        .res_ready (take),
        .idle      (idle_x),
        .res       (res_x)
    );

    dapsp_lane #(
        .POS_BITS      (POS_BITS),
        .INTEGRAL_BITS (INTEGRAL_BITS),
        .ANGLE_MIN     (ANGLE_MIN),
        .ANGLE_MAX     (ANGLE_MAX)
    ) u_lane_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .err       (err_y),
        .gains     (gains_y),
        .res_ready (take),
        .idle      (idle_y),
        .res       (res_y)
    );

    // ---------------- merge and output register ----------------
    dapsp_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_x     (res_x),
        .res_y     (res_y),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_angle_x (m_angle_x),
        .m_angle_y (m_angle_y),
        .m_pwm_x   (m_pwm_x),
        .m_pwm_y   (m_pwm_y)
    );

endmodule

@@ rtl/dapsp_checker.sv @@
// Port-level checker for the two-axis servo controller, bound to the top level.
`include "assert_macros.svh"

module dapsp_checker import dapsp_pkg::*; #(
    parameter int ANGLE_MIN = 45,
    parameter int ANGLE_MAX = 135
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ANGLE_BITS-1:0] m_angle_x,
    input logic [ANGLE_BITS-1:0] m_angle_y,
    input logic [PWM_BITS-1:0]   m_pwm_x,
    input logic [PWM_BITS-1:0]   m_pwm_y
);

    // stalled result holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_angle_x) && $stable(m_angle_y) && $stable(m_pwm_x) && $stable(m_pwm_y))

    // only one request in flight
    `ASSERT_CLK(a_single_flight, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // a new result only appears while a request was being worked on
    `ASSERT_CLK(a_result_source, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready))

    // clamped angles stay in range when the limits are ordered
    `ASSERT_CLK(a_angle_range, aclk, aresetn, m_valid |-> (ANGLE_MIN > ANGLE_MAX) || (m_angle_x >= ANGLE_MIN && m_angle_x <= ANGLE_MAX && m_angle_y >= ANGLE_MIN && m_angle_y <= ANGLE_MAX))

    // compare values never fall below the offset
    `ASSERT_NEVER(a_pwm_floor, aclk, aresetn, m_valid && (m_pwm_x < PWM_OFFSET || m_pwm_y < PWM_OFFSET))

endmodule

bind dual_axis_pid_servo_pwm dapsp_checker #(
    .ANGLE_MIN (ANGLE_MIN),
    .ANGLE_MAX (ANGLE_MAX)
) u_dapsp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_angle_x (m_angle_x),
    .m_angle_y (m_angle_y),
    .m_pwm_x   (m_pwm_x),
    .m_pwm_y   (m_pwm_y)
);
